// ===== design/cfd_pkg.sv =====
// Package: shared types and constants for the COBS frame decoder.
`timescale 1ns / 1ps

package cfd_pkg;

    localparam int MAX_FRAME = 256;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 9;
    localparam int OUT_DATA_W = 24;

    localparam logic [LEN_W-1:0]  MAX_FRAME_LEN = LEN_W'(MAX_FRAME);
    localparam logic [BYTE_W-1:0] CODE_NO_ZERO  = 8'hFF;
    localparam logic [BYTE_W-1:0] DELIMITER     = 8'h00;

    typedef enum logic
    {
        KIND_DATA   = 1'b0,
        KIND_REPORT = 1'b1
    } cfd_kind_t;

    typedef struct packed
    {
        cfd_kind_t          kind;
        logic [BYTE_W-1:0]  data;
        logic               good;
        logic [LEN_W-1:0]   len;
    } cfd_result_t;

endpackage

// ===== design/cfd_in_reg.sv =====
// Input register stage holding one received byte.
`timescale 1ns / 1ps

module cfd_in_reg
    import cfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_byte,
    input  logic              advance,
    output logic              held,
    output logic [BYTE_W-1:0] held_byte
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_byte;
        end
    end

    assign held      = valid_reg;
    assign held_byte = byte_reg;

endmodule

// ===== design/cfd_decode.sv =====
// COBS decode state, held-back byte, running sum and frame report logic.
`timescale 1ns / 1ps

module cfd_decode
    import cfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              res_valid,
    output cfd_result_t       res
);

    logic [BYTE_W-1:0] block_left_reg,  block_left_next;
    logic [BYTE_W-1:0] last_code_reg,   last_code_next;
    logic [BYTE_W-1:0] held_byte_reg,   held_byte_next;
    logic              held_valid_reg,  held_valid_next;
    logic [BYTE_W-1:0] sum_reg,         sum_next;
    logic [LEN_W-1:0]  count_reg,       count_next;
    logic              ovf_reg,         ovf_next;

    logic              take;
    logic [BYTE_W-1:0] take_byte;

    always_comb
    begin
        block_left_next = block_left_reg;
        last_code_next  = last_code_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        res             = '0;
        res_valid       = 1'b0;
        take            = 1'b0;
        take_byte       = '0;

        if (rx_byte == DELIMITER)
        begin
            res_valid       = 1'b1;
            res.kind        = KIND_REPORT;
            res.good        = held_valid_reg && !ovf_reg && (count_reg != '0)
                              && (sum_reg == held_byte_reg);
            res.len         = count_reg;
            block_left_next = '0;
            last_code_next  = CODE_NO_ZERO;
            held_byte_next  = '0;
            held_valid_next = 1'b0;
            sum_next        = '0;
            count_next      = '0;
            ovf_next        = 1'b0;
        end
        else if (block_left_reg != '0)
        begin
            block_left_next = block_left_reg - 8'd1;
            take            = 1'b1;
            take_byte       = rx_byte;
        end
        else
        begin
            // code byte: implied zero unless the previous code was a full group
            take            = (last_code_reg != CODE_NO_ZERO);
            last_code_next  = rx_byte;
            block_left_next = rx_byte - 8'd1;
        end

        if (take)
        begin
            if (held_valid_reg)
            begin
                res_valid = 1'b1;
                res.kind  = KIND_DATA;
                res.data  = held_byte_reg;
                sum_next  = sum_reg + held_byte_reg;
            end
            held_byte_next  = take_byte;
            held_valid_next = 1'b1;
            if (count_reg == MAX_FRAME_LEN)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_left_reg <= '0;
            last_code_reg  <= CODE_NO_ZERO;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            sum_reg        <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (advance)
        begin
            block_left_reg <= block_left_next;
            last_code_reg  <= last_code_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

// ===== design/cfd_out_reg.sv =====
// Result register driving the output stream.
`timescale 1ns / 1ps

module cfd_out_reg
    import cfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  res_valid,
    input  cfd_result_t           res,
    output logic                  room,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    logic        valid_reg;
    logic        valid_next;
    cfd_result_t res_reg;

    assign room = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res_valid;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {6'd0, res_reg.len, res_reg.good, res_reg.data};

endmodule

// ===== design/cobs_frame_decoder_with_checksum_core.sv =====
// Top level: COBS frame decoder with 8-bit additive checksum check.
//
//  channel  | dir | payload                                        | sideband
//  ---------+-----+------------------------------------------------+-----------------
//  s_*      | in  | tdata[7:0] rx_byte                             | -
//  m_*      | out | tdata[7:0] out_byte, [8] frame_good, [17:9] len | tuser out_kind
//
// One byte beat per cycle while the result register is not stalled. A byte enters the
// input register, then the decode logic updates the frame state and loads the result
// register in the same cycle. Bytes that produce no result (code bytes, the first
// decoded byte) still advance, but only while the result register has room.
// A stalled result register holds the input register.
// Reset clears all frame state; no warm-up after reset.
`timescale 1ns / 1ps

module cobs_frame_decoder_with_checksum_core
    import cfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] out_byte, [8] frame_good, [17:9] frame_len
    output logic                  m_tuser    // [0] out_kind
);

    logic              in_held;
    logic [BYTE_W-1:0] in_byte;
    logic              room;
    logic              advance;
    logic              res_valid;
    cfd_result_t       res;

    assign advance = in_held && room;

    cfd_in_reg u_in
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_byte    (s_tdata),
        .advance   (advance),
        .held      (in_held),
        .held_byte (in_byte)
    );

    cfd_decode u_dec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .rx_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    cfd_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .room      (room),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_data_beat_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_DATA) |-> (m_tdata[17:8] == '0))
        else $error("data beat carries report fields");

    a_good_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_REPORT && m_tdata[8]) |-> (m_tdata[17:9] != '0))
        else $error("good report with zero length");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[17:9] <= MAX_FRAME_LEN))
        else $error("frame length beyond maximum");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_held && m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    a_report_from_delim: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_byte == DELIMITER) |=> (m_tvalid && m_tuser == KIND_REPORT))
        else $error("delimiter did not produce a report");

endmodule
